@@ hw/rtl/mms_pkg.sv @@
package mms_pkg;

  // Operand geometry: an operand is CHUNKS chunks of CHUNK_BITS bits.
  localparam int unsigned CHUNK_BITS = 8;
  localparam int unsigned CHUNKS     = 8;
  localparam int unsigned W          = CHUNK_BITS * CHUNKS;
  localparam int unsigned FIELD_BITS = 64;
  localparam int unsigned CNT_BITS   = $clog2(W);

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_SUB = 2'd1,
    OP_MOD = 2'd2,
    OP_NOP = 2'd3
  } op_e;

  localparam logic ST_OK       = 1'b0;
  localparam logic ST_ZERO_MOD = 1'b1;

  // Fit a 64-bit field into the working width: truncates or zero-extends.
  function automatic logic [W-1:0] to_work(input logic [FIELD_BITS-1:0] x);
    logic [W+FIELD_BITS-1:0] t;
    t = {{W{1'b0}}, x};
    return t[W-1:0];
  endfunction

  // Fit a working-width value into a 64-bit field.
  function automatic logic [FIELD_BITS-1:0] to_field(input logic [W-1:0] x);
    logic [W+FIELD_BITS-1:0] t;
    t = {{FIELD_BITS{1'b0}}, x};
    return t[FIELD_BITS-1:0];
  endfunction

endpackage

@@ hw/rtl/mms_req_if.sv @@
interface mms_req_if;
  import mms_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [1:0]            req_type;
  logic [FIELD_BITS-1:0] operand_a;
  logic [FIELD_BITS-1:0] operand_b;

  modport source (output valid, req_type, operand_a, operand_b, input ready);
  modport sink   (input valid, req_type, operand_a, operand_b, output ready);
endinterface

@@ hw/rtl/mms_rsp_if.sv @@
interface mms_rsp_if;
  import mms_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] result_low;
  logic [FIELD_BITS-1:0] result_high;
  logic                  status;

  modport source (output valid, result_low, result_high, status, input ready);
  modport sink   (input valid, result_low, result_high, status, output ready);
endinterface

@@ hw/rtl/multiprecision_mul_sub_mod.sv @@
// Multiply, subtract and nonzero modulo pass through the bit-serial datapath (BUSY) before DONE;
// a zero modulus or the unused operation code goes straight from IDLE to DONE.
// A new request is taken only in IDLE, since the single shared shift datapath serves one request
// at a time and retires one operand bit per cycle. The result register frees the datapath early.
// Reset: rst_ni is asynchronous and active low; it idles the sequencer and empties the
// result register. Datapath registers are not reset.
module multiprecision_mul_sub_mod (
  input  logic      clk_i,
  input  logic      rst_ni,
  mms_req_if.sink   req_i,
  mms_rsp_if.source rsp_o
);
  import mms_pkg::*;

  // The sequencer idles until a request arrives, runs the bit-serial datapath in BUSY (skipped for a
  // zero modulus or the unused operation code), then waits in DONE until the result register is free.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_BUSY = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  op_e                 op_q, op_d;
  logic                zero_q, zero_d;   // modulo with a zero modulus
  logic                borrow_q, borrow_d;

  // Shared datapath registers. Their roles depend on the operation:
  //   multiply: a_q multiplicand, hi_q:lo_q product, lo_q starts as the multiplier.
  //   subtract: lo_q minuend shifting right into the difference, hi_q subtrahend.
  //   modulo:   a_q modulus, lo_q dividend shifting left, hi_q partial remainder.
  logic [W-1:0] a_q, a_d;
  logic [W-1:0] hi_q, hi_d;
  logic [W-1:0] lo_q, lo_d;

  // Result register, which decouples the datapath from a stalled consumer.
  logic                  rsp_valid_q, rsp_valid_d;
  logic [FIELD_BITS-1:0] res_low_q, res_low_d;
  logic [FIELD_BITS-1:0] res_high_q, res_high_d;
  logic                  res_st_q, res_st_d;

  logic         req_fire;
  logic         rsp_free;
  logic [W:0]   mul_sum;
  logic         sub_bit;
  logic [W:0]   mod_shift;
  logic [W+1:0] mod_diff;
  logic [W-1:0] in_a;
  logic [W-1:0] in_b;

  assign req_fire = req_i.valid && req_i.ready;
  assign rsp_free = !rsp_valid_q || rsp_o.ready;
  assign in_a     = to_work(req_i.operand_a);
  assign in_b     = to_work(req_i.operand_b);

  // One step of each operation. Multiply is shift-and-add from the low multiplier bit,
  // subtract is a one-bit full subtractor with a borrow flop, and modulo is a restoring
  // step that brings down the next dividend bit.
  assign mul_sum   = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : {(W+1){1'b0}});
  assign sub_bit   = lo_q[0] ^ hi_q[0] ^ borrow_q;
  assign mod_shift = {hi_q, lo_q[W-1]};
  assign mod_diff  = {1'b0, mod_shift} - {2'b00, a_q};

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    op_d        = op_q;
    zero_d      = zero_q;
    borrow_d    = borrow_q;
    a_d         = a_q;
    hi_d        = hi_q;
    lo_d        = lo_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    res_low_d   = res_low_q;
    res_high_d  = res_high_q;
    res_st_d    = res_st_q;

    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          op_d     = op_e'(req_i.req_type);
          cnt_d    = CNT_BITS'(W - 1);
          borrow_d = 1'b0;
          zero_d   = 1'b0;
          state_d  = S_BUSY;
          case (op_e'(req_i.req_type))
            OP_MUL: begin
              a_d  = in_a;
              hi_d = '0;
              lo_d = in_b;
            end
            OP_SUB: begin
              a_d  = in_a;
              hi_d = in_b;
              lo_d = in_a;
            end
            OP_MOD: begin
              a_d  = in_b;
              hi_d = '0;
              lo_d = in_a;
              // A zero modulus skips the datapath and returns the dividend as is.
              if (in_b == '0) begin
                zero_d  = 1'b1;
                state_d = S_DONE;
              end
            end
            default: begin
              a_d     = in_a;
              hi_d    = '0;
              lo_d    = '0;
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_BUSY: begin
        case (op_q)
          OP_MUL: begin
            hi_d = mul_sum[W:1];
            lo_d = {mul_sum[0], lo_q[W-1:1]};
          end
          OP_SUB: begin
            lo_d     = {sub_bit, lo_q[W-1:1]};
            hi_d     = {1'b0, hi_q[W-1:1]};
            borrow_d = (!lo_q[0] && hi_q[0]) || (!(lo_q[0] ^ hi_q[0]) && borrow_q);
          end
          OP_MOD: begin
            lo_d = {lo_q[W-2:0], 1'b0};
            hi_d = mod_diff[W+1] ? mod_shift[W-1:0] : mod_diff[W-1:0];
          end
          default: begin
            hi_d = hi_q;
          end
        endcase
        cnt_d = cnt_q - CNT_BITS'(1);
        if (cnt_q == '0) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (rsp_free) begin
          rsp_valid_d = 1'b1;
          res_low_d   = to_field((op_q == OP_MOD && !zero_q) ? hi_q : lo_q);
          res_high_d  = (op_q == OP_MUL) ? to_field(hi_q) : '0;
          res_st_d    = zero_q ? ST_ZERO_MOD : ST_OK;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
      cnt_q       <= '0;
      op_q        <= OP_NOP;
      zero_q      <= 1'b0;
      borrow_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      cnt_q       <= cnt_d;
      op_q        <= op_d;
      zero_q      <= zero_d;
      borrow_q    <= borrow_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    hi_q       <= hi_d;
    lo_q       <= lo_d;
    res_low_q  <= res_low_d;
    res_high_q <= res_high_d;
    res_st_q   <= res_st_d;
  end

  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.result_low  = res_low_q;
  assign rsp_o.result_high = res_high_q;
  assign rsp_o.status      = res_st_q;

`ifndef SYNTHESIS
  // A new result only appears when the sequencer hands one over from DONE.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q == S_DONE))
    else $error("result appeared without a finished request");

  // The last datapath step always leads into DONE.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BUSY && cnt_q == '0) |=> (state_q == S_DONE))
    else $error("datapath overran its bit count");

  // A zero-modulus flag never carries a high half.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && res_st_q == ST_ZERO_MOD) |-> (res_high_q == '0))
    else $error("zero-modulus result has a nonzero high half");

  // Leaving DONE must load the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && rsp_free) |=> rsp_valid_q)
    else $error("finished request was lost");
`endif

endmodule
